### src/bhpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpc_pkg
// shared types and constants of the hull point contents block: stream
// and field widths, item kinds, configuration indexes and walker states
// ----------------------------------------------------------------------------
package bhpc_pkg;

	// stream widths
	localparam int IN_TDATA_W  = 184;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 1;

	// field widths
	localparam int NUM_W   = 12;
	localparam int CHILD_W = 13;
	localparam int TYPE_W  = 3;
	localparam int COORD_W = 32;
	localparam int NRM_W   = 16;
	localparam int CONT_W  = 5;

	// item kinds (s_tuser)
	localparam logic [1:0] KIND_NODE_WR  = 2'd0;
	localparam logic [1:0] KIND_PLANE_WR = 2'd1;
	localparam logic [1:0] KIND_QUERY    = 2'd2;

	// configuration register indexes
	localparam logic CFG_FIRST_NODE = 1'b0;
	localparam logic CFG_LAST_NODE  = 1'b1;

	// number of axial plane types
	localparam logic [2:0] AXIAL_TYPES = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NODE_WR,
		ST_NODE,
		ST_PLANE,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### src/bsp_hull_point_contents_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_hull_point_contents_top
// clip-node tree walker that classifies a point against a hull
// ----------------------------------------------------------------------------
// The block keeps a clip-node table and a plane table in on-chip synchronous
// memories; both are loaded with input transfers (kind 0 writes a node,
// kind 1 writes a plane) and answer nothing. A query transfer (kind 2) gives
// a start node and a Q16.16 point; the walker reads the node, reads its
// plane, forms the signed distance and follows the back child when it is
// negative, the front child otherwise, until a negative child gives the leaf
// contents (codes below -16 read as -16). Each visited node takes the steps
// node read, plane read, multiply, then sum and branch, and the input is not
// ready until the query ends; a node write also holds off the input
// while a reciprocal multiply reduces the plane number modulo PLANE_COUNT;
// a plane write goes straight in while idle. A node number outside first_node ..
// last_node or not below NODE_COUNT, or a walk longer than NODE_COUNT nodes,
// ends the query with bad_node set and contents 0. Tables come up undefined:
// there is no clearing pass, and a query must only touch written entries.
// The result sits in an output register, so the walker starts the next item
// while a result still waits on m_tready.
// ----------------------------------------------------------------------------
module bsp_hull_point_contents_top
	import bhpc_pkg::*;
#(
	parameter int NODE_COUNT  = 4096,
	parameter int PLANE_COUNT = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// entry_index, plane_ref, child_front, child_back, plane_type,
	// plane_dist, coord_x, coord_y, coord_z, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// contents, zero pad
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// bad_node
	output logic [OUT_TUSER_W-1:0]      m_tuser,
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [NUM_W-1:0]       cfg_wdata
);

	localparam int NAW   = $clog2(NODE_COUNT);
	localparam int PAW   = $clog2(PLANE_COUNT);
	localparam int VIS_W = $clog2(NODE_COUNT + 1);
	localparam int NODE_W = 2 * CHILD_W + NUM_W;
	localparam int OFF_W  = TYPE_W + COORD_W;
	localparam int NRMS_W = 3 * NRM_W;
	// plane entry: normals in the low bits, dist and type above
	localparam int PLANE_W = OFF_W + NRMS_W;

	// plane number modulo PLANE_COUNT by reciprocal multiply, exact for 12 bits
	localparam int MOD_SHIFT = NUM_W + PAW;
	localparam int PROD_W    = MOD_SHIFT + NUM_W;
	localparam longint RECIP = ((64'd1 << MOD_SHIFT) + PLANE_COUNT - 1) / PLANE_COUNT;
	localparam logic [NUM_W-1:0] PC_LO = NUM_W'(PLANE_COUNT);

	localparam logic [NUM_W-1:0]        FIRST_RST  = '0;
	localparam logic [NUM_W-1:0]        LAST_RST   = '1;
	localparam logic signed [NRM_W-1:0] AXIAL_ONE  = 16'sh4000;
	localparam logic [CONT_W-1:0]       LEAF_FLOOR = 5'b10000;

	localparam int SUM_W  = 51;
	localparam int PROD_M = NRM_W + COORD_W;

	// input field slices
	logic [1:0]               in_kind;
	logic [NUM_W-1:0]         in_entry_index;
	logic [NUM_W-1:0]         in_plane_ref;
	logic [CHILD_W-1:0]       in_child_front;
	logic [CHILD_W-1:0]       in_child_back;
	logic [TYPE_W-1:0]        in_plane_type;
	logic [COORD_W-1:0]       in_plane_dist;
	logic signed [COORD_W-1:0] in_coord_x;
	logic signed [COORD_W-1:0] in_coord_y;
	logic signed [COORD_W-1:0] in_coord_z;

	assign in_kind        = s_tuser;
	assign in_entry_index = s_tdata[11:0];
	assign in_plane_ref   = s_tdata[23:12];
	assign in_child_front = s_tdata[36:24];
	assign in_child_back  = s_tdata[49:37];
	assign in_plane_type  = s_tdata[52:50];
	assign in_plane_dist  = s_tdata[84:53];
	assign in_coord_x     = s_tdata[116:85];
	assign in_coord_y     = s_tdata[148:117];
	assign in_coord_z     = s_tdata[180:149];

	state_t state_q, state_d;

	// configuration
	logic [NUM_W-1:0] first_node_q;
	logic [NUM_W-1:0] last_node_q;

	// walker registers
	logic signed [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic [VIS_W-1:0]          visits_q;
	logic [CONT_W-1:0]         res_contents_q;
	logic                      res_bad_q;
	logic signed [PROD_M-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [COORD_W-1:0] dist_s1;

	// node write pipeline
	logic [NAW-1:0]            nw_slot_q;
	logic                      nw_ok_q;
	logic [2*CHILD_W-1:0]      nw_child_q;
	logic [NUM_W-1:0]          nw_pref_q;
	logic [PROD_W-1:0]         nw_prod_s1;
	logic [NUM_W-1:0]          nw_quot;
	logic [NUM_W-1:0]          nw_rem;

	// output register
	logic                      out_valid_q;
	logic [CONT_W-1:0]         out_contents_q;
	logic                      out_bad_q;
	logic                      out_free;

	// memories
	logic [NODE_W-1:0]  node_mem  [NODE_COUNT];
	logic [PLANE_W-1:0] plane_mem [PLANE_COUNT];
	logic [NODE_W-1:0]  node_rdata_q;
	logic [PLANE_W-1:0] plane_rdata_q;
	logic [NRMS_W-1:0]  nrm_rdata;
	logic [OFF_W-1:0]   off_rdata;

	logic              node_re, node_we, plane_re, plane_we;
	logic [NAW-1:0]    node_raddr;
	logic [NODE_W-1:0] node_wdata;
	logic [PAW-1:0]    plane_raddr, plane_waddr;

	// walk decisions
	logic [NUM_W-1:0]          chk_num;
	logic                      chk_bad;
	logic                      visit_full;
	logic signed [SUM_W-1:0]   dist_sum;
	logic [CHILD_W-1:0]        child_sel;
	logic                      child_leaf;
	logic [CONT_W-1:0]         leaf_code;
	logic [TYPE_W-1:0]         pl_type;
	logic signed [NRM_W-1:0]   coef_x, coef_y, coef_z;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_node_q <= FIRST_RST;
			last_node_q  <= LAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_NODE: first_node_q <= cfg_wdata;
				CFG_LAST_NODE:  last_node_q  <= cfg_wdata;
			endcase
		end
	end

	// ------------------------------------------------------- walk decisions
	// sum of the three products less dist scaled to Q.30; only the sign matters
	assign dist_sum = SUM_W'(prod_x_s1) + SUM_W'(prod_y_s1) + SUM_W'(prod_z_s1)
		- (SUM_W'(dist_s1) <<< 14);
	assign child_sel  = dist_sum[SUM_W-1] ? node_rdata_q[NODE_W-1 -: CHILD_W]
		: node_rdata_q[NUM_W +: CHILD_W];
	assign child_leaf = child_sel[CHILD_W-1];
	// leaf codes below -16 clamp to -16
	assign leaf_code  = (&child_sel[CHILD_W-1:CONT_W-1]) ? child_sel[CONT_W-1:0]
		: LEAF_FLOOR;

	assign chk_num    = (state_q == ST_SUM) ? child_sel[NUM_W-1:0] : in_entry_index;
	assign visit_full = (state_q == ST_SUM) && (visits_q == VIS_W'(NODE_COUNT));
	assign chk_bad    = (chk_num < first_node_q) || (chk_num > last_node_q) ||
		(32'(chk_num) >= NODE_COUNT) || visit_full;

	// plane entry fields
	assign nrm_rdata = plane_rdata_q[NRMS_W-1:0];
	assign off_rdata = plane_rdata_q[PLANE_W-1 -: OFF_W];

	// axial planes pick one coordinate with a unit coefficient
	assign pl_type = off_rdata[OFF_W-1 -: TYPE_W];
	always_comb begin
		if (pl_type < AXIAL_TYPES) begin
			coef_x = (pl_type == 3'd0) ? AXIAL_ONE : '0;
			coef_y = (pl_type == 3'd1) ? AXIAL_ONE : '0;
			coef_z = (pl_type == 3'd2) ? AXIAL_ONE : '0;
		end else begin
			coef_x = nrm_rdata[15:0];
			coef_y = nrm_rdata[31:16];
			coef_z = nrm_rdata[47:32];
		end
	end

	// remainder of the plane number
	assign nw_quot = nw_prod_s1[PROD_W-1 -: NUM_W];
	assign nw_rem  = nw_pref_q - NUM_W'(nw_quot * PC_LO);

	// ------------------------------------------------------------ next state
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_kind)
						KIND_NODE_WR: state_d = ST_NODE_WR;
						KIND_QUERY:   state_d = chk_bad ? ST_DONE : ST_NODE;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_NODE_WR: state_d = ST_IDLE;
			ST_NODE:    state_d = ST_PLANE;
			ST_PLANE:   state_d = ST_SUM;
			ST_SUM:     state_d = (child_leaf || chk_bad) ? ST_DONE : ST_NODE;
			ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		s_tready = 1'b0;
		node_re  = 1'b0;
		node_we  = 1'b0;
		plane_re = 1'b0;
		plane_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				node_re  = s_tvalid && (in_kind == KIND_QUERY) && !chk_bad;
				plane_we = s_tvalid && (in_kind == KIND_PLANE_WR) &&
					(32'(in_entry_index) < PLANE_COUNT);
			end
			ST_NODE_WR: node_we = nw_ok_q;
			ST_NODE:    plane_re = 1'b1;
			ST_SUM:     node_re = !child_leaf && !chk_bad;
			default: begin
			end
		endcase
	end

	assign node_raddr  = NAW'(chk_num);
	assign node_wdata  = {nw_child_q, nw_rem};
	assign plane_raddr = PAW'(node_rdata_q[NUM_W-1:0]);
	assign plane_waddr = PAW'(in_entry_index);

	// -------------------------------------------------------------- memories
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[nw_slot_q] <= node_wdata;
		end
		if (node_re) begin
			node_rdata_q <= node_mem[node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (plane_we) begin
			plane_mem[plane_waddr] <= {in_plane_type, in_plane_dist,
				in_coord_z[15:0], in_coord_y[15:0], in_coord_x[15:0]};
		end
		if (plane_re) begin
			plane_rdata_q <= plane_mem[plane_raddr];
		end
	end

	// -------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			// node write fields and first half of the modulo
			nw_slot_q  <= NAW'(in_entry_index);
			nw_ok_q    <= 32'(in_entry_index) < NODE_COUNT;
			nw_child_q <= {in_child_back, in_child_front};
			nw_pref_q  <= in_plane_ref;
			nw_prod_s1 <= PROD_W'(in_plane_ref) * PROD_W'(RECIP);
			// query point
			pt_x_q     <= in_coord_x;
			pt_y_q     <= in_coord_y;
			pt_z_q     <= in_coord_z;
		end
		if (state_q == ST_PLANE) begin
			prod_x_s1 <= PROD_M'(coef_x) * PROD_M'(pt_x_q);
			prod_y_s1 <= PROD_M'(coef_y) * PROD_M'(pt_y_q);
			prod_z_s1 <= PROD_M'(coef_z) * PROD_M'(pt_z_q);
			dist_s1   <= off_rdata[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visits_q <= '0;
		end else if (state_q == ST_IDLE) begin
			visits_q <= VIS_W'(1);
		end else if (state_q == ST_SUM && !child_leaf && !chk_bad) begin
			visits_q <= visits_q + VIS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE || state_q == ST_SUM) begin
			if (state_q == ST_SUM && child_leaf) begin
				res_contents_q <= leaf_code;
				res_bad_q      <= 1'b0;
			end else begin
				res_contents_q <= '0;
				res_bad_q      <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_contents_q <= res_contents_q;
			out_bad_q      <= res_bad_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - CONT_W){1'b0}}, out_contents_q};
	assign m_tuser  = out_bad_q;

endmodule
`default_nettype wire

### src/bhpc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpc_chk
// port-level checks on the result stream of the hull point contents block
// ----------------------------------------------------------------------------
module bhpc_chk
	import bhpc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [OUT_TUSER_W-1:0] m_tuser
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a bad walk reports contents 0
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[CONT_W-1:0] == '0)
		else $error("bad node result with nonzero contents");

	// a good walk ends on a negative leaf code
	a_leaf_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[CONT_W-1])
		else $error("leaf contents not negative");

	// pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:CONT_W] == '0)
		else $error("nonzero pad bits in result");

endmodule

bind bsp_hull_point_contents_top bhpc_chk u_bhpc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
